@@ rtl/rnmv_pkg.sv @@
// Shared types and constants of the replicated notepad majority voter.
// Used by the CSR block, the vote sequencer, the top level and the checker.
package rnmv_pkg;

   // command codes
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_FEED    = 2'd1;
   localparam logic [1:0] CMD_OBSERVE = 2'd2;

   // register indexes (bit 2 of the byte address)
   localparam logic REG_REPLICA_COUNT = 1'b0;
   localparam logic REG_STATE_BYTES   = 1'b1;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [3:0] REPLICA_COUNT_RESET = 4'd3;
   localparam logic [6:0] STATE_BYTES_RESET   = 7'd16;

   typedef struct packed {
      logic [1:0] cmd;
      logic [2:0] replica;
      logic [5:0] byte_index;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [7:0] byte_out;
      logic [5:0] out_index;
      logic       last;
      logic       valid_res;
      logic [3:0] best_votes;
   } rsp_type;

   typedef struct packed {
      logic [3:0] replica_count;
      logic [6:0] state_bytes;
   } cfg_type;

endpackage

@@ rtl/rnmv_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
module rnmv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr_a,
   input  logic [$clog2(DEPTH)-1:0] raddr_b,
   output logic [WIDTH-1:0]         rdata_a,
   output logic [WIDTH-1:0]         rdata_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_a_ff;
   logic [WIDTH-1:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a_ff <= mem_ff[raddr_a];
      rdata_b_ff <= mem_ff[raddr_b];
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

@@ rtl/rnmv_csr.sv @@
// APB-style configuration registers: replica count and state size.
// Depends on rnmv_pkg.
module rnmv_csr
   import rnmv_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [3:0] replica_count_ff, replica_count_in;
   logic [6:0] state_bytes_ff, state_bytes_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      replica_count_in = replica_count_ff;
      state_bytes_in   = state_bytes_ff;
      if (wr_en) begin
         unique case (paddr[2])
            REG_REPLICA_COUNT: replica_count_in = pwdata[3:0];
            REG_STATE_BYTES:   state_bytes_in   = pwdata[6:0];
            default:           ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         replica_count_ff <= REPLICA_COUNT_RESET;
         state_bytes_ff   <= STATE_BYTES_RESET;
      end else begin
         replica_count_ff <= replica_count_in;
         state_bytes_ff   <= state_bytes_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_REPLICA_COUNT: prdata = CSR_DATA_W'(replica_count_ff);
         REG_STATE_BYTES:   prdata = CSR_DATA_W'(state_bytes_ff);
         default:           prdata = '0;
      endcase
   end

   assign cfg.replica_count = replica_count_ff;
   assign cfg.state_bytes   = state_bytes_ff;

endmodule

@@ rtl/rnmv_seq.sv @@
// Vote sequencer: flip vote, pairwise region compare, copy-out and result register.
// Depends on rnmv_pkg; drives the ports of one rnmv_ram.
module rnmv_seq
   import rnmv_pkg::*;
#(
   parameter int MAX_REPLICAS    = 8,
   parameter int MAX_STATE_BYTES = 64,
   parameter int DEPTH           = MAX_REPLICAS * 2 * MAX_STATE_BYTES,
   parameter int AW              = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_item,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_item,
   output logic          ram_we,
   output logic [AW-1:0] ram_waddr,
   output logic [7:0]    ram_wdata,
   output logic [AW-1:0] ram_raddr_a,
   output logic [AW-1:0] ram_raddr_b,
   input  logic [7:0]    ram_rdata_a,
   input  logic [7:0]    ram_rdata_b
);

   localparam int RIDX_W = (MAX_REPLICAS > 1) ? $clog2(MAX_REPLICAS) : 1;
   localparam int CNT_W  = $clog2(MAX_REPLICAS + 1);
   localparam int BIDX_W = (MAX_STATE_BYTES > 1) ? $clog2(MAX_STATE_BYTES) : 1;
   localparam int SZ_W   = $clog2(MAX_STATE_BYTES + 1);

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_VOTE,
      S_CAND,
      S_PAIR,
      S_RD,
      S_CMP,
      S_OUT_RD,
      S_OUT_EMIT
   } state_type;

   state_type         state_ff, state_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic              is_feed_ff, is_feed_in;
   logic [RIDX_W-1:0] issuer_ff, issuer_in;
   logic              rd_buf_ff, rd_buf_in;
   logic [CNT_W-1:0]  c_ff, c_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [BIDX_W-1:0] j_ff, j_in;
   logic [CNT_W-1:0]  votes_ff, votes_in;
   logic [CNT_W-1:0]  best_ff, best_in;
   logic              win_ff, win_in;
   logic              flip_ff [MAX_REPLICAS];
   logic              flip_in [MAX_REPLICAS];
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_item_ff, rsp_item_in;

   logic [CNT_W-1:0]  n;
   logic [CNT_W-1:0]  maj;
   logic [SZ_W-1:0]   sz;
   logic              vote_rd;
   logic              last_byte;
   logic              out_free;
   logic              wr_ok;
   logic [RIDX_W-1:0] wr_rep;
   logic [7:0]        emit_byte;

   function automatic logic [AW-1:0] addr_of(logic [RIDX_W-1:0] rep, logic buf_sel,
                                             logic [BIDX_W-1:0] off, logic [SZ_W-1:0] size);
      addr_of = AW'({rep, buf_sel}) * AW'(size) + AW'(off);
   endfunction

   // clamp the configuration into range
   always_comb begin
      if (cfg.replica_count == '0) begin
         n = CNT_W'(1);
      end else if (int'(cfg.replica_count) > MAX_REPLICAS) begin
         n = CNT_W'(MAX_REPLICAS);
      end else begin
         n = CNT_W'(cfg.replica_count);
      end
      if (cfg.state_bytes == '0) begin
         sz = SZ_W'(1);
      end else if (int'(cfg.state_bytes) > MAX_STATE_BYTES) begin
         sz = SZ_W'(MAX_STATE_BYTES);
      end else begin
         sz = SZ_W'(cfg.state_bytes);
      end
   end

   assign maj = CNT_W'(1) + (n >> 1);

   // flip vote; on feedforward, replicas below the issuer count as already flipped
   always_comb begin
      logic [CNT_W-1:0] ones;
      logic             f;
      ones = '0;
      for (int i = 0; i < MAX_REPLICAS; i++) begin
         f = flip_ff[i];
         if (is_feed_ff && (i < int'(issuer_ff))) begin
            f = ~f;
         end
         if ((i < int'(n)) && f) begin
            ones = ones + CNT_W'(1);
         end
      end
      vote_rd = (ones >= maj);
   end

   assign last_byte = ((SZ_W'(j_ff) + SZ_W'(1)) == sz);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign wr_rep    = RIDX_W'(req_item.replica);
   assign wr_ok     = (int'(req_item.replica) < MAX_REPLICAS)
                   && (int'(req_item.byte_index) < int'(sz));
   assign emit_byte = win_ff ? ram_rdata_a : 8'd0;

   assign ram_raddr_a = addr_of(c_ff[RIDX_W-1:0], rd_buf_ff, j_ff, sz);
   assign ram_raddr_b = addr_of(k_ff[RIDX_W-1:0], rd_buf_ff, j_ff, sz);

   // store write port: clearing pass, byte writes, copy of the result (winner or zeros)
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = clr_ff;
      ram_wdata = 8'd0;
      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
         end
         S_IDLE: begin
            if (req_valid && (req_item.cmd == CMD_WRITE) && wr_ok) begin
               ram_we    = 1'b1;
               ram_waddr = addr_of(wr_rep, flip_ff[wr_rep],
                                   BIDX_W'(req_item.byte_index), sz);
               ram_wdata = req_item.byte_in;
            end
         end
         S_OUT_EMIT: begin
            if (out_free && is_feed_ff) begin
               ram_we    = 1'b1;
               ram_waddr = addr_of(issuer_ff, ~rd_buf_ff, j_ff, sz);
               ram_wdata = emit_byte;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      is_feed_in   = is_feed_ff;
      issuer_in    = issuer_ff;
      rd_buf_in    = rd_buf_ff;
      c_in         = c_ff;
      k_in         = k_ff;
      j_in         = j_ff;
      votes_in     = votes_ff;
      best_in      = best_ff;
      win_in       = win_ff;
      flip_in      = flip_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_item.cmd)
                  CMD_FEED: begin
                     if (int'(req_item.replica) < int'(n)) begin
                        is_feed_in = 1'b1;
                        issuer_in  = wr_rep;
                        state_in   = S_VOTE;
                     end
                  end
                  CMD_OBSERVE: begin
                     is_feed_in = 1'b0;
                     issuer_in  = '0;
                     state_in   = S_VOTE;
                  end
                  default: ;
               endcase
            end
         end
         S_VOTE: begin
            rd_buf_in = vote_rd;
            c_in      = '0;
            best_in   = '0;
            state_in  = S_CAND;
         end
         S_CAND: begin
            if (({1'b0, c_ff} + {1'b0, maj}) <= {1'b0, n}) begin
               votes_in = CNT_W'(1);
               k_in     = c_ff + CNT_W'(1);
               state_in = S_PAIR;
            end else begin
               // no majority: emit zeros
               win_in   = 1'b0;
               j_in     = '0;
               state_in = S_OUT_RD;
            end
         end
         S_PAIR: begin
            if (k_ff >= n) begin
               if (votes_ff > best_ff) begin
                  best_in = votes_ff;
               end
               if (votes_ff >= maj) begin
                  win_in   = 1'b1;
                  j_in     = '0;
                  state_in = S_OUT_RD;
               end else begin
                  c_in     = c_ff + CNT_W'(1);
                  state_in = S_CAND;
               end
            end else begin
               j_in     = '0;
               state_in = S_RD;
            end
         end
         S_RD: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (ram_rdata_a != ram_rdata_b) begin
               k_in     = k_ff + CNT_W'(1);
               state_in = S_PAIR;
            end else if (last_byte) begin
               votes_in = votes_ff + CNT_W'(1);
               k_in     = k_ff + CNT_W'(1);
               state_in = S_PAIR;
            end else begin
               j_in     = j_ff + BIDX_W'(1);
               state_in = S_RD;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_EMIT;
         end
         S_OUT_EMIT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_item_in.byte_out   = emit_byte;
               rsp_item_in.out_index  = 6'(j_ff);
               rsp_item_in.last       = last_byte;
               rsp_item_in.valid_res  = win_ff;
               rsp_item_in.best_votes = 4'(best_ff);
               if (last_byte) begin
                  if (is_feed_ff) begin
                     flip_in[issuer_ff] = ~rd_buf_ff;
                  end
                  state_in = S_IDLE;
               end else begin
                  j_in     = j_ff + BIDX_W'(1);
                  state_in = S_OUT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MAX_REPLICAS; i++) begin
            flip_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         flip_ff      <= flip_in;
      end
      is_feed_ff  <= is_feed_in;
      issuer_ff   <= issuer_in;
      rd_buf_ff   <= rd_buf_in;
      c_ff        <= c_in;
      k_ff        <= k_in;
      j_ff        <= j_in;
      votes_ff    <= votes_in;
      best_ff     <= best_in;
      win_ff      <= win_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

@@ rtl/replicated_notepad_majority_voter.sv @@
// Replicated notepad with majority voting over replica state regions.
// Depends on rnmv_pkg, rnmv_csr, rnmv_seq and rnmv_ram.
//
// After reset the block sweeps the region store to zero, one byte a cycle, over all
// MAX_REPLICAS*2*MAX_STATE_BYTES bytes (1024 at the defaults); req_stall stays high
// meanwhile and configuration writes are taken as usual. A write item is written to
// the store straight from the idle state. A feedforward or observe item occupies the
// sequencer for the flip vote, the candidates tried with their compared pairs and the
// copy-out, and also while the result side stalls; each pair is compared up to and
// including the first mismatching byte (at most S bytes, S the state size) and S
// bytes are then copied out. Byte pairs are compared through the store's two
// registered read ports. Results leave through an output register, so the next item
// is taken while the last result still waits.
module replicated_notepad_majority_voter
   import rnmv_pkg::*;
#(
   parameter int MAX_REPLICAS    = 8,
   parameter int MAX_STATE_BYTES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_item,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_item,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int DEPTH = MAX_REPLICAS * 2 * MAX_STATE_BYTES;
   localparam int AW    = $clog2(DEPTH);

   cfg_type       cfg;
   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_wdata;
   logic [AW-1:0] ram_raddr_a;
   logic [AW-1:0] ram_raddr_b;
   logic [7:0]    ram_rdata_a;
   logic [7:0]    ram_rdata_b;

   rnmv_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rnmv_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .we      (ram_we),
      .waddr   (ram_waddr),
      .wdata   (ram_wdata),
      .raddr_a (ram_raddr_a),
      .raddr_b (ram_raddr_b),
      .rdata_a (ram_rdata_a),
      .rdata_b (ram_rdata_b)
   );

   rnmv_seq #(
      .MAX_REPLICAS    (MAX_REPLICAS),
      .MAX_STATE_BYTES (MAX_STATE_BYTES),
      .DEPTH           (DEPTH),
      .AW              (AW)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .ram_we      (ram_we),
      .ram_waddr   (ram_waddr),
      .ram_wdata   (ram_wdata),
      .ram_raddr_a (ram_raddr_a),
      .ram_raddr_b (ram_raddr_b),
      .ram_rdata_a (ram_rdata_a),
      .ram_rdata_b (ram_rdata_b)
   );

endmodule

@@ rtl/rnmv_checker.sv @@
// Port-level checks for the majority voter, bound to the top level.
// Depends on rnmv_pkg and replicated_notepad_majority_voter.
module rnmv_checker
   import rnmv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_item
);

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // the store sweep keeps the input closed right after reset
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("input open during store clearing");

   // while a result sequence is incomplete no new item is taken
   a_busy_mid_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.last |-> req_stall)
      else $error("input open before last byte produced");

   // no majority means zero bytes
   a_zero_invalid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.valid_res |-> rsp_item.byte_out == 8'd0)
      else $error("non-zero byte without majority");

endmodule

bind replicated_notepad_majority_voter rnmv_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_item  (rsp_item)
);

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for replicated_notepad_majority_voter: a directed table, then random phases.
// A shadow of the region store, flip bits and registers predicts the result items; typed rows give their own values.
// Depends on rnmv_pkg and the RTL below rtl/.
module tb;
   import rnmv_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int MAX_REPS       = 8;
   localparam int MAX_BYTES      = 64;
   localparam int STORE_DEPTH    = MAX_REPS * 2 * MAX_BYTES;
   localparam int SETTLE_CYCLES  = 300;
   localparam int HOLD_CYCLES    = 2500;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct packed {
      req_type    item;
      logic       typed;
      logic [7:0] t_byte;
      logic       t_valid;
      logic [3:0] t_best;
   } dir_row_type;

   // default registers: three replicas of sixteen bytes
   localparam dir_row_type DIR_ROWS [20] = '{
      '{'{CMD_OBSERVE, 3'd0, 6'd0,  8'h00}, 1'b1, 8'h00, 1'b1, 4'd3},
      '{'{CMD_UNUSED,  3'd7, 6'd63, 8'hFF}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_FEED,    3'd5, 6'd0,  8'h00}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_FEED,    3'd7, 6'd0,  8'h00}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_WRITE,   3'd0, 6'd63, 8'hFF}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_WRITE,   3'd7, 6'd0,  8'hFF}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_WRITE,   3'd0, 6'd0,  8'hFF}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_WRITE,   3'd0, 6'd15, 8'hAA}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_OBSERVE, 3'd3, 6'd0,  8'h00}, 1'b1, 8'h00, 1'b1, 4'd2},
      '{'{CMD_FEED,    3'd0, 6'd0,  8'h00}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_FEED,    3'd1, 6'd0,  8'h00}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_FEED,    3'd2, 6'd0,  8'h00}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_OBSERVE, 3'd0, 6'd0,  8'h00}, 1'b1, 8'h00, 1'b1, 4'd3},
      '{'{CMD_WRITE,   3'd1, 6'd3,  8'h55}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_WRITE,   3'd2, 6'd3,  8'h0F}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_WRITE,   3'd0, 6'd3,  8'hA0}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_OBSERVE, 3'd0, 6'd0,  8'h00}, 1'b1, 8'h00, 1'b0, 4'd1},
      '{'{CMD_FEED,    3'd0, 6'd0,  8'h00}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_WRITE,   3'd0, 6'd9,  8'h7E}, 1'b0, 8'h00, 1'b0, 4'd0},
      '{'{CMD_OBSERVE, 3'd0, 6'd0,  8'h00}, 1'b0, 8'h00, 1'b0, 4'd0}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_item;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_item;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   replicated_notepad_majority_voter i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   logic [7:0] shadow_store [STORE_DEPTH];
   logic       shadow_flip [MAX_REPS];
   logic [3:0] shadow_reps;
   logic [6:0] shadow_bytes;
   rsp_type    voted_q [$];
   int         fail_count = 0;
   int         idle_cycles = 0;
   bit         quiet_phase = 1'b0;
   bit         hold_request = 1'b0;

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int unsigned act_reps();
      if (shadow_reps < 1) return 1;
      if (shadow_reps > MAX_REPS) return MAX_REPS;
      return shadow_reps;
   endfunction

   function automatic int unsigned region_len();
      if (shadow_bytes < 1) return 1;
      if (shadow_bytes > MAX_BYTES) return MAX_BYTES;
      return shadow_bytes;
   endfunction

   function automatic int unsigned slot(input int unsigned rep, input int unsigned bank,
                                        input int unsigned off);
      return ((rep * 2 + bank) * region_len() + off) % STORE_DEPTH;
   endfunction

   // replicas below the issuer are treated as already flipped when adjusting
   function automatic bit pick_bank(input bit adjust, input int unsigned issuer);
      int unsigned n;
      int unsigned ones;
      n = act_reps();
      ones = 0;
      for (int unsigned i = 0; i < n; i++)
         ones += int'(shadow_flip[i] ^ (adjust && (i < issuer)));
      return ones >= 1 + n / 2;
   endfunction

   function automatic bit regions_agree(input int unsigned a, input int unsigned b,
                                        input int unsigned bank);
      for (int unsigned k = 0; k < region_len(); k++)
         if (shadow_store[slot(a, bank, k)] != shadow_store[slot(b, bank, k)]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic req_type mk_req(input logic [1:0] cmd, input int unsigned rep,
                                      input int unsigned idx, input int unsigned data);
      req_type r;
      r.cmd        = cmd;
      r.replica    = 3'(rep);
      r.byte_index = 6'(idx);
      r.byte_in    = 8'(data);
      return r;
   endfunction

   task automatic predict_item(input req_type it, input bit typed, input logic [7:0] t_byte,
                               input logic t_valid, input logic [3:0] t_best);
      logic [7:0]  winner [MAX_BYTES];
      rsp_type     res;
      int unsigned n;
      int unsigned maj;
      int unsigned sz;
      int unsigned best;
      int unsigned votes;
      bit          rd;
      bit          found;
      n = act_reps();
      maj = 1 + n / 2;
      sz = region_len();
      best = 0;
      found = 1'b0;
      rd = 1'b0;
      case (it.cmd)
         CMD_WRITE: begin
            if (it.byte_index < sz)
               shadow_store[slot(it.replica, shadow_flip[it.replica], it.byte_index)] = it.byte_in;
            return;
         end
         CMD_FEED: begin
            if (it.replica >= n) return;
            rd = pick_bank(1'b1, it.replica);
         end
         CMD_OBSERVE: rd = pick_bank(1'b0, 0);
         default: return;
      endcase
      for (int unsigned c = 0; !found && (c + maj <= n); c++) begin
         votes = 1;
         for (int unsigned k = c + 1; k < n; k++)
            if (regions_agree(c, k, rd)) votes++;
         if (votes > best) best = votes;
         if (votes >= maj) begin
            found = 1'b1;
            for (int unsigned k = 0; k < sz; k++) winner[k] = shadow_store[slot(c, rd, k)];
         end
      end
      if (!found)
         for (int unsigned k = 0; k < sz; k++) winner[k] = 8'h00;
      if (it.cmd == CMD_FEED) begin
         for (int unsigned k = 0; k < sz; k++) shadow_store[slot(it.replica, !rd, k)] = winner[k];
         shadow_flip[it.replica] = !rd;
      end
      for (int unsigned k = 0; k < sz; k++) begin
         res.byte_out   = typed ? t_byte : winner[k];
         res.out_index  = 6'(k);
         res.last       = (k + 1 == sz);
         res.valid_res  = typed ? t_valid : found;
         res.best_votes = typed ? t_best : 4'(best);
         voted_q.push_back(res);
      end
   endtask

   task automatic send_req(input req_type it, input bit typed, input logic [7:0] t_byte,
                           input logic t_valid, input logic [3:0] t_best);
      int unsigned gap;
      gap = quiet_phase ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      predict_item(it, typed, t_byte, t_valid, t_best);
   endtask

   task automatic send_plain(input req_type it);
      send_req(it, 1'b0, 8'h00, 1'b0, 4'd0);
   endtask

   task automatic csr_write(input logic reg_idx, input int unsigned value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_idx == REG_REPLICA_COUNT) shadow_reps = 4'(value);
      else shadow_bytes = 7'(value);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // drop valid, wait for every result, then let any result-free item finish
   task automatic settle();
      req_valid <= 1'b0;
      while (voted_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic random_burst(input int unsigned n_items);
      int unsigned sent;
      int unsigned n;
      int unsigned sz;
      int unsigned roll;
      int unsigned idx;
      int unsigned data;
      sent = 0;
      while (sent < n_items) begin
         n = act_reps();
         sz = region_len();
         roll = $urandom_range(0, 99);
         if (roll < 45) begin
            // same byte to every active replica, each copy now and then spoilt
            idx = $urandom_range(0, sz - 1);
            data = $urandom;
            for (int unsigned r = 0; r < n; r++)
               send_plain(mk_req(CMD_WRITE, r, idx,
                                 ($urandom_range(0, 7) == 0) ? $urandom : data));
            sent += n;
         end else begin
            if (roll < 60)
               send_plain(mk_req(CMD_WRITE, $urandom_range(0, MAX_REPS - 1),
                                 $urandom_range(0, sz - 1), $urandom));
            else if (roll < 80)
               send_plain(mk_req(CMD_FEED, $urandom_range(0, n - 1), $urandom, $urandom));
            else if (roll < 90)
               send_plain(mk_req(CMD_OBSERVE, $urandom, $urandom, $urandom));
            else
               case ($urandom_range(0, 2))
                  0: send_plain(mk_req(CMD_UNUSED, $urandom, $urandom, $urandom));
                  1: send_plain(mk_req(CMD_WRITE, $urandom, $urandom_range(0, 63), $urandom));
                  default: send_plain(mk_req(CMD_FEED, $urandom_range(0, MAX_REPS - 1),
                                             $urandom, $urandom));
               endcase
            sent++;
         end
      end
   endtask

   task automatic run_phase(input int unsigned reps, input int unsigned size_val,
                            input int unsigned n_items, input bit quiet, input bit squeeze);
      settle();
      csr_write(REG_REPLICA_COUNT, reps);
      csr_write(REG_STATE_BYTES, size_val);
      quiet_phase = quiet;
      if (squeeze) begin
         hold_request = 1'b1;
         repeat (4) send_plain(mk_req(CMD_OBSERVE, 0, 0, 0));
      end
      random_burst(n_items);
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (voted_q.size() == 0) begin
         $error("unexpected result item: byte_out %0h out_index %0d", got.byte_out, got.out_index);
         fail_count++;
         return;
      end
      want = voted_q.pop_front();
      if (got.byte_out !== want.byte_out) begin
         $error("byte_out: expected %0h, got %0h", want.byte_out, got.byte_out);
         fail_count++;
      end
      if (got.out_index !== want.out_index) begin
         $error("out_index: expected %0d, got %0d", want.out_index, got.out_index);
         fail_count++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, got.last);
         fail_count++;
      end
      if (got.valid_res !== want.valid_res) begin
         $error("valid_res: expected %0b, got %0b", want.valid_res, got.valid_res);
         fail_count++;
      end
      if (got.best_votes !== want.best_votes) begin
         $error("best_votes: expected %0d, got %0d", want.best_votes, got.best_votes);
         fail_count++;
      end
   endtask

   // result side: random hold-off per item, plus one long stretch on request
   initial begin : rsp_sink
      int unsigned wait_n;
      rsp_stall = 1'b0;
      forever begin
         wait_n = quiet_phase ? 0 : $urandom_range(0, 13);
         if (hold_request) begin
            wait_n += HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (wait_n > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin : watch
      if (reset) begin
         idle_cycles = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_item);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
             (psel && penable && pwrite && pready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   initial begin : stimulus
      reset     = 1'b1;
      req_valid = 1'b0;
      req_item  = '0;
      psel      = 1'b0;
      penable   = 1'b0;
      pwrite    = 1'b0;
      paddr     = '0;
      pwdata    = '0;
      foreach (shadow_store[i]) shadow_store[i] = 8'h00;
      foreach (shadow_flip[i]) shadow_flip[i] = 1'b0;
      shadow_reps  = REPLICA_COUNT_RESET;
      shadow_bytes = STATE_BYTES_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (DIR_ROWS[i])
         send_req(DIR_ROWS[i].item, DIR_ROWS[i].typed, DIR_ROWS[i].t_byte,
                  DIR_ROWS[i].t_valid, DIR_ROWS[i].t_best);

      run_phase(1, 1, 25, 1'b0, 1'b0);
      run_phase(8, 64, 12, 1'b0, 1'b0);
      run_phase(0, 0, 15, 1'b0, 1'b0);
      run_phase(15, 127, 8, 1'b1, 1'b0);
      run_phase(3, 16, 30, 1'b1, 1'b1);
      run_phase(5, 7, 25, 1'b0, 1'b0);
      run_phase(2, 3, 25, 1'b0, 1'b0);
      run_phase(4, 8, 25, 1'b1, 1'b0);
      run_phase(7, 5, 20, 1'b0, 1'b0);
      settle();

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/rnmv_pkg.sv
rtl/rnmv_ram.sv
rtl/rnmv_csr.sv
rtl/rnmv_seq.sv
rtl/replicated_notepad_majority_voter.sv
rtl/rnmv_checker.sv
dv/tb.sv
